// ===== src/slc_pkg.sv =====
// shared types and constants of the source line classifier
`default_nettype none
package slc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        CLASS_CODE    = 2'd0,
        CLASS_BLANK   = 2'd1,
        CLASS_COMMENT = 2'd2
    } line_class_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // what one scanned item produces
    typedef struct packed {
        logic        fire;
        logic        line_valid;
        line_class_t line_class;
        logic        file_done;
    } slc_event_t;

endpackage
`default_nettype wire

// ===== src/slc_text_if.sv =====
// channel carrying source bytes and end-of-file items
`default_nettype none
interface slc_text_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] char_code;

    modport source (output valid, output operation, output char_code, input ready);
    modport sink (input valid, input operation, input char_code, output ready);
endinterface
`default_nettype wire

// ===== src/slc_tally_if.sv =====
// channel carrying line classes and running totals
`default_nettype none
interface slc_tally_if;
    logic        valid;
    logic        ready;
    logic        line_valid;
    logic [1:0]  line_class;
    logic [31:0] lines_total;
    logic [31:0] lines_blank;
    logic [31:0] lines_comment;
    logic        file_done;

    modport source (output valid, output line_valid, output line_class,
                    output lines_total, output lines_blank, output lines_comment,
                    output file_done, input ready);
    modport sink (input valid, input line_valid, input line_class,
                  input lines_total, input lines_blank, input lines_comment,
                  input file_done, output ready);
endinterface
`default_nettype wire

// ===== src/slc_scanner.sv =====
// per-line scan state: strings, comments, pair lookahead and line close
`default_nettype none
module slc_scanner
    import slc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       operation,
    input  wire logic [7:0] char_code,
    output slc_event_t      ev
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_SLASH = 2'd1,
        PEND_STAR  = 2'd2
    } pend_t;

    logic  block_reg, block_next;
    logic  str_reg, str_next;
    logic  par_reg, par_next;
    logic  stop_reg, stop_next;
    pend_t pend_reg, pend_next;
    logic  nonblank_reg, nonblank_next;
    logic  commented_reg, commented_next;
    logic  open_reg, open_next;
    logic  is_ws;

    function automatic line_class_t classify(input logic nonblank, input logic commented);
        line_class_t cls;
        if (!nonblank)
            cls = CLASS_BLANK;
        else if (commented)
            cls = CLASS_COMMENT;
        else
            cls = CLASS_CODE;
        return cls;
    endfunction

    assign is_ws = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                   (char_code == CH_CR) || (char_code == CH_LF);

    always_comb
    begin
        block_next     = block_reg;
        str_next       = str_reg;
        par_next       = par_reg;
        stop_next      = stop_reg;
        pend_next      = pend_reg;
        nonblank_next  = nonblank_reg;
        commented_next = commented_reg;
        open_next      = open_reg;
        ev.fire        = 1'b0;
        ev.line_valid  = 1'b0;
        ev.line_class  = CLASS_CODE;
        ev.file_done   = 1'b0;

        if (step)
        begin
            if (operation == OP_EOF)
            begin
                ev.fire       = 1'b1;
                ev.line_valid = open_reg;
                ev.line_class = open_reg ? classify(nonblank_reg, commented_reg) : CLASS_CODE;
                ev.file_done  = 1'b1;
                // end of file also drops an unterminated block comment
                block_next     = 1'b0;
                str_next       = 1'b0;
                par_next       = 1'b0;
                stop_next      = 1'b0;
                pend_next      = PEND_NONE;
                nonblank_next  = 1'b0;
                commented_next = 1'b0;
                open_next      = 1'b0;
            end
            else
            begin
                open_next = 1'b1;
                if (!is_ws)
                    nonblank_next = 1'b1;

                if (!stop_reg)
                begin
                    if (pend_reg == PEND_SLASH)
                    begin
                        pend_next = PEND_NONE;
                        if (char_code == CH_SLASH)
                        begin
                            commented_next = 1'b1;
                            stop_next      = 1'b1;
                        end
                        else if (char_code == CH_STAR)
                        begin
                            block_next     = 1'b1;
                            commented_next = 1'b1;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    else if (pend_reg == PEND_STAR && char_code == CH_SLASH)
                    begin
                        pend_next  = PEND_NONE;
                        block_next = 1'b0;
                    end
                    else
                    begin
                        pend_next = PEND_NONE;
                        if (char_code == CH_CR || char_code == CH_LF)
                        begin
                            stop_next = 1'b1;
                        end
                        else if (char_code == CH_QUOTE)
                        begin
                            if (!par_reg)
                                str_next = !str_reg;
                        end
                        else if (str_reg)
                        begin
                            // skipped inside a string
                            str_next = str_reg;
                        end
                        else if (block_reg)
                        begin
                            commented_next = 1'b1;
                            if (char_code == CH_STAR)
                                pend_next = PEND_STAR;
                        end
                        else if (char_code == CH_SLASH)
                        begin
                            pend_next = PEND_SLASH;
                        end
                        else if (char_code != CH_SPACE && char_code != CH_TAB)
                        begin
                            stop_next = 1'b1;
                        end
                    end
                end

                par_next = (char_code == CH_BSLASH) ? !par_reg : 1'b0;

                if (char_code == CH_LF)
                begin
                    ev.fire        = 1'b1;
                    ev.line_valid  = 1'b1;
                    ev.line_class  = classify(nonblank_next, commented_next);
                    str_next       = 1'b0;
                    par_next       = 1'b0;
                    stop_next      = 1'b0;
                    pend_next      = PEND_NONE;
                    nonblank_next  = 1'b0;
                    commented_next = 1'b0;
                    open_next      = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg     <= 1'b0;
            str_reg       <= 1'b0;
            par_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            pend_reg      <= PEND_NONE;
            nonblank_reg  <= 1'b0;
            commented_reg <= 1'b0;
            open_reg      <= 1'b0;
        end
        else
        begin
            block_reg     <= block_next;
            str_reg       <= str_next;
            par_reg       <= par_next;
            stop_reg      <= stop_next;
            pend_reg      <= pend_next;
            nonblank_reg  <= nonblank_next;
            commented_reg <= commented_next;
            open_reg      <= open_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/slc_counters.sv =====
// saturating line totals, cleared after each end of file
`default_nettype none
module slc_counters
    import slc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  slc_event_t      ev,
    output count_t          total_next,
    output count_t          blank_next,
    output count_t          comment_next
);

    count_t total_reg;
    count_t blank_reg;
    count_t comment_reg;

    function automatic count_t sat_inc(input count_t v, input logic inc);
        count_t r;
        if (inc && v != '1)
            r = v + count_t'(1);
        else
            r = v;
        return r;
    endfunction

    assign total_next   = sat_inc(total_reg, ev.fire && ev.line_valid);
    assign blank_next   = sat_inc(blank_reg,
                                  ev.fire && ev.line_valid && ev.line_class == CLASS_BLANK);
    assign comment_next = sat_inc(comment_reg,
                                  ev.fire && ev.line_valid && ev.line_class == CLASS_COMMENT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            blank_reg   <= '0;
            comment_reg <= '0;
        end
        else if (ev.fire && ev.file_done)
        begin
            total_reg   <= '0;
            blank_reg   <= '0;
            comment_reg <= '0;
        end
        else
        begin
            total_reg   <= total_next;
            blank_reg   <= blank_next;
            comment_reg <= comment_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/c_source_line_classifier_core.sv =====
// top level of the source line classifier
//
//  channel | role | payload
//  --------+------+---------------------------------------------------------------
//  text    | sink | operation, char_code
//  tally   | src  | line_valid, line_class, lines_total, lines_blank, lines_comment,
//          |      | file_done
//
// one item per cycle sustained unless tally stalls; a result is loaded into the result
// register as its item leaves the input register (scan and counter update in one pass)
// only a newline or an end of file produces a result; other bytes update state alone
// a stalled tally holds the result and the input register, and text.ready drops
// only when both are full; reset clears all scan state and the totals
`default_nettype none
module c_source_line_classifier_core
    import slc_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    slc_text_if.sink  text,
    slc_tally_if.source tally
);

    logic        stage_valid_reg, stage_valid_next;
    logic        stage_op_reg;
    logic [7:0]  stage_char_reg;
    logic        stage_adv;
    logic        stage_fire;

    logic        res_valid_reg, res_valid_next;
    logic        res_line_valid_reg;
    line_class_t res_class_reg;
    logic [FIELD_WIDTH-1:0] res_total_reg;
    logic [FIELD_WIDTH-1:0] res_blank_reg;
    logic [FIELD_WIDTH-1:0] res_comment_reg;
    logic        res_done_reg;

    slc_event_t  ev;
    count_t      total_next;
    count_t      blank_next;
    count_t      comment_next;

    assign stage_adv  = !res_valid_reg || tally.ready;
    assign stage_fire = stage_valid_reg && stage_adv;
    assign text.ready = !stage_valid_reg || stage_adv;

    slc_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (stage_fire),
        .operation (stage_op_reg),
        .char_code (stage_char_reg),
        .ev        (ev)
    );

    slc_counters u_counters (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev           (ev),
        .total_next   (total_next),
        .blank_next   (blank_next),
        .comment_next (comment_next)
    );

    always_comb
    begin
        if (text.valid && text.ready)
            stage_valid_next = 1'b1;
        else if (stage_fire)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;

        if (ev.fire)
            res_valid_next = 1'b1;
        else if (tally.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            stage_op_reg   <= text.operation;
            stage_char_reg <= text.char_code;
        end
        if (ev.fire)
        begin
            res_line_valid_reg <= ev.line_valid;
            res_class_reg      <= ev.line_class;
            res_total_reg      <= FIELD_WIDTH'(total_next);
            res_blank_reg      <= FIELD_WIDTH'(blank_next);
            res_comment_reg    <= FIELD_WIDTH'(comment_next);
            res_done_reg       <= ev.file_done;
        end
    end

    assign tally.valid         = res_valid_reg;
    assign tally.line_valid    = res_line_valid_reg;
    assign tally.line_class    = res_class_reg;
    assign tally.lines_total   = res_total_reg;
    assign tally.lines_blank   = res_blank_reg;
    assign tally.lines_comment = res_comment_reg;
    assign tally.file_done     = res_done_reg;

`ifndef ASSERT_OFF
    // text is only throttled when both the input register and the result are full
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (stage_valid_reg && res_valid_reg))
        else $error("text throttled while a register is free");

    // a blank total can never run ahead of the line total
    a_blank_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        tally.valid |-> (tally.lines_blank <= tally.lines_total))
        else $error("blank count above line count");

    // a closed blank line always shows up in the blank total
    a_blank_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (tally.valid && tally.line_valid && tally.line_class == CLASS_BLANK)
            |-> (tally.lines_blank != '0))
        else $error("blank line not counted");
`endif

endmodule
`default_nettype wire
